// ----- sv/rlfp_pkg.sv -----
// Package for the RC link frame parser: shared constants, types and the CRC-8 step.
// No dependencies.
package rlfp_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 64;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QPTR_W              = 2;
   localparam int CSR_IDX_W           = 8;

   localparam logic [7:0] CRC_POLY       = 8'hD5;
   localparam logic [7:0] SYNC_RESET     = 8'd200;
   localparam logic [7:0] CHTYPE_RESET   = 8'd22;
   localparam logic [7:0] CHAN_FRAME_LEN = 8'd24;   // type + 22 payload + crc
   localparam int         PAYLOAD_BITS   = 176;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_VALUE   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_TYPE = 8'd1;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } rlfp_byte_type;

   function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] d);
      logic [7:0] r;
      r = c ^ d;
      for (int b = 0; b < 8; b++) begin
         if (r[7]) r = {r[6:0], 1'b0} ^ CRC_POLY;
         else      r = {r[6:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ----- sv/rlfp_channels.sv -----
// Handshake channel interfaces of the RC link frame parser.
// No dependencies.
interface rlfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rlfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  channel_index;
   logic [10:0] channel_value;
   logic        last_of_frame;
   modport source (output valid, output channel_index, output channel_value,
                   output last_of_frame, input ready);
   modport sink   (input valid, input channel_index, input channel_value,
                   input last_of_frame, output ready);
endinterface

// ----- sv/rlfp_byte_queue.sv -----
// Front end: accepts received bytes into a short queue for the parser.
// Depends on rlfp_pkg and rlfp_channels.
module rlfp_byte_queue (
   input  logic                   clock,
   input  logic                   reset,
   rlfp_req_if.sink               req_chan,
   output rlfp_pkg::rlfp_byte_type head_o,
   input  logic                   pop_i
);
   import rlfp_pkg::*;

   logic [7:0]      q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic            push;
   logic            pop;

   assign req_chan.ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push = req_chan.valid && req_chan.ready;
   assign pop  = pop_i && (count_ff != '0);

   assign head_o.valid = (count_ff != '0);
   assign head_o.data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= req_chan.rx_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/rlfp_parser.sv -----
// Back end: frame store, parse sequencer, CRC-8 and channel unpacking.
// Depends on rlfp_pkg and rlfp_channels.
module rlfp_parser #(
   parameter int MAX_FRAME_BYTES = rlfp_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             sync_value,
   input  logic [7:0]             channels_frame_type,
   input  rlfp_pkg::rlfp_byte_type head_i,
   output logic                   pop_o,
   rlfp_rsp_if.source             rsp_chan
);
   import rlfp_pkg::*;

   localparam int IDX_W = $clog2(MAX_FRAME_BYTES);
   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [CNT_W-1:0] FULL      = CNT_W'(MAX_FRAME_BYTES);
   localparam logic [8:0]       MAX_TOTAL = 9'(MAX_FRAME_BYTES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_SYNC  = 3'd2;
   localparam logic [2:0] S_LEN   = 3'd3;
   localparam logic [2:0] S_CRC   = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [7:0] mem [MAX_FRAME_BYTES];
   logic [7:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             wr_en;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] off_ff, off_in;
   logic [7:0]       flen_ff, flen_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       ftype_ff, ftype_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic [3:0]       ch_ff, ch_in;
   logic [1:0]       frames_ff, frames_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_idx_ff, rsp_idx_in;
   logic [10:0] rsp_val_ff, rsp_val_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [8:0]  total;
   logic [CNT_W-1:0] last_off;

   function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] b,
                                             input logic [CNT_W-1:0] o);
      logic [SUM_W-1:0] s;
      s = SUM_W'(b) + SUM_W'(o);
      if (s >= SUM_W'(MAX_FRAME_BYTES)) s = s - SUM_W'(MAX_FRAME_BYTES);
      return s[IDX_W-1:0];
   endfunction

   assign total    = {1'b0, rd_data_ff} + 9'd2;
   assign last_off = CNT_W'({1'b0, flen_ff} + 9'd1);

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.channel_index = rsp_idx_ff;
   assign rsp_chan.channel_value = rsp_val_ff;
   assign rsp_chan.last_of_frame = rsp_last_ff;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      off_in      = off_ff;
      flen_in     = flen_ff;
      crc_in      = crc_ff;
      ftype_in    = ftype_ff;
      payload_in  = payload_ff;
      ch_in       = ch_ff;
      frames_in   = frames_ff;
      rd_addr     = head_ff;
      wr_addr     = head_ff;
      wr_en       = 1'b0;
      pop_o       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (head_i.valid) begin
               pop_o     = 1'b1;
               frames_in = '0;
               if (!(fill_ff == '0 && head_i.data != sync_value)) begin
                  wr_en = 1'b1;
                  if (fill_ff == FULL) begin
                     // oldest byte makes room
                     wr_addr = head_ff;
                     head_in = wrap(head_ff, CNT_W'(1));
                  end else begin
                     wr_addr = wrap(head_ff, fill_ff);
                     fill_in = fill_ff + 1'b1;
                  end
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            rd_addr = head_ff;
            if (fill_ff < CNT_W'(3)) state_in = S_IDLE;
            else                     state_in = S_SYNC;
         end
         S_SYNC: begin
            if (rd_data_ff != sync_value) begin
               head_in  = wrap(head_ff, CNT_W'(1));
               fill_in  = fill_ff - 1'b1;
               state_in = S_CHECK;
            end else begin
               rd_addr  = wrap(head_ff, CNT_W'(1));
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            flen_in = rd_data_ff;
            if (rd_data_ff < 8'd2 || total > MAX_TOTAL) begin
               head_in  = wrap(head_ff, CNT_W'(1));
               fill_in  = fill_ff - 1'b1;
               state_in = S_CHECK;
            end else if (9'(fill_ff) < total) begin
               state_in = S_IDLE;
            end else begin
               rd_addr  = wrap(head_ff, CNT_W'(2));
               off_in   = CNT_W'(2);
               crc_in   = '0;
               state_in = S_CRC;
            end
         end
         S_CRC: begin
            if (off_ff == last_off) begin
               if (rd_data_ff == crc_ff) begin
                  head_in = wrap(head_ff, CNT_W'({1'b0, flen_ff} + 9'd2));
                  fill_in = fill_ff - CNT_W'({1'b0, flen_ff} + 9'd2);
                  if (ftype_ff == channels_frame_type && flen_ff == CHAN_FRAME_LEN &&
                      frames_ff != 2'd2) begin
                     ch_in    = '0;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_CHECK;
                  end
               end else begin
                  head_in  = wrap(head_ff, CNT_W'(1));
                  fill_in  = fill_ff - 1'b1;
                  state_in = S_CHECK;
               end
            end else begin
               crc_in = crc8_step(crc_ff, rd_data_ff);
               if (off_ff == CNT_W'(2)) ftype_in = rd_data_ff;
               else payload_in = {rd_data_ff, payload_ff[PAYLOAD_BITS-1:8]};
               off_in  = off_ff + 1'b1;
               rd_addr = wrap(head_ff, off_ff + 1'b1);
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = ch_ff;
               rsp_val_in   = payload_ff[10:0];
               rsp_last_in  = (ch_ff == 4'd15);
               payload_in   = {11'd0, payload_ff[PAYLOAD_BITS-1:11]};
               ch_in        = ch_ff + 1'b1;
               if (ch_ff == 4'd15) begin
                  frames_in = frames_ff + 1'b1;
                  state_in  = S_CHECK;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= head_i.data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      off_ff     <= off_in;
      flen_ff    <= flen_in;
      crc_ff     <= crc_in;
      ftype_ff   <= ftype_in;
      payload_ff <= payload_in;
      ch_ff      <= ch_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_val_ff <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         frames_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- sv/rc_link_frame_parser.sv -----
// RC link frame parser top level: configuration registers, byte queue, parser.
// Depends on rlfp_pkg, rlfp_channels, rlfp_byte_queue and rlfp_parser.
//
// Usage: req_chan carries one received link byte per transaction. Frames are
// sync, length, type, payload, CRC-8 (poly 0xD5 over type and payload). Each
// good channel frame (22-byte payload) yields 16 transactions on rsp_chan,
// channel 0..15 in order, 11-bit values, last_of_frame set on channel 15.
// csr_wr_en/csr_index/csr_wr_data write sync_value (index 0) and
// channels_frame_type (index 1); other indexes are ignored. Write only while idle.
// Flow: a byte waits in a 4-entry queue, then the parser checks the header
// (sync, length) and makes a CRC pass over the frame store (one memory read
// per cycle), then outputs the 16 channel values of a channel frame; at most
// two channel frames are output per byte taken, later ones are dropped. A
// rescan after a bad frame repeats this per dropped byte.
// Reset empties the queue and the frame store and restores register defaults.
// When rsp_chan stalls the parser holds its channel; the queue keeps taking
// bytes until it fills, then req_chan.ready drops.
module rc_link_frame_parser #(
   parameter int MAX_FRAME_BYTES = rlfp_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   rlfp_req_if.sink                        req_chan,
   rlfp_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [rlfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]                      csr_wr_data
);
   import rlfp_pkg::*;

   logic [7:0]    sync_ff, sync_in;
   logic [7:0]    chtype_ff, chtype_in;
   rlfp_byte_type q_head;
   logic          q_pop;

   // register file, no read-back
   always_comb begin
      sync_in   = sync_ff;
      chtype_in = chtype_ff;
      if (csr_wr_en) begin
         if (csr_index == CSR_SYNC_VALUE)   sync_in   = csr_wr_data;
         if (csr_index == CSR_CHANNEL_TYPE) chtype_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff   <= SYNC_RESET;
         chtype_ff <= CHTYPE_RESET;
      end else begin
         sync_ff   <= sync_in;
         chtype_ff <= chtype_in;
      end
   end

   // front: byte intake
   rlfp_byte_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .head_o   (q_head),
      .pop_i    (q_pop)
   );

   // back: frame store and parse sequencer
   rlfp_parser #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parser (
      .clock               (clock),
      .reset               (reset),
      .sync_value          (sync_ff),
      .channels_frame_type (chtype_ff),
      .head_i              (q_head),
      .pop_o               (q_pop),
      .rsp_chan            (rsp_chan)
   );

endmodule
